// ===== design/lsm_pkg.sv =====
// lsm_pkg: shared types and constants for the load score monitor
// holds widths, register indexes, sequencer states and divider op codes
// no dependencies
`default_nettype none

package lsm_pkg;

    localparam int CNT_W    = 48;
    localparam int FRAC_W   = 15;
    localparam int Q_W      = FRAC_W + 1;
    localparam int RATE_W   = 48;
    localparam int IV_W     = 16;
    localparam int TPS_W    = 14;
    localparam int BW_W     = 48;
    localparam int WGT_W    = 16;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int MS_W     = 10;

    localparam int NUM_W    = CNT_W + MS_W + FRAC_W;
    localparam int DEN_W    = CNT_W + TPS_W;
    localparam int IT_W     = $clog2(NUM_W);
    localparam int PROD_W   = WGT_W + Q_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int SCORE_W  = SUM_W - FRAC_W;

    localparam logic [MS_W-1:0]   MS_PER_S = MS_W'(1000);
    localparam logic [Q_W-1:0]    ONE_Q    = Q_W'(1) << FRAC_W;
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    localparam logic [IV_W-1:0]  RST_INTERVAL = IV_W'(1000);
    localparam logic [TPS_W-1:0] RST_TPS      = TPS_W'(100);
    localparam logic [BW_W-1:0]  RST_BW       = BW_W'(12500000);
    localparam logic [WGT_W-1:0] RST_CPU_WGT  = WGT_W'(16384);
    localparam logic [WGT_W-1:0] RST_NET_WGT  = WGT_W'(16384);
    localparam logic [WGT_W-1:0] RST_BUSY_THR = WGT_W'(26214);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_TICKS_PER_SEC   = 3'd1,
        REG_MAX_BANDWIDTH   = 3'd2,
        REG_CPU_WEIGHT      = 3'd3,
        REG_NET_WEIGHT      = 3'd4,
        REG_BUSY_THRESHOLD  = 3'd5,
        REG_CPU_OFF         = 3'd6,
        REG_NET_OFF         = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CPU_SET,
        S_RATE_SET,
        S_TERM_SET,
        S_DIV,
        S_SCORE1,
        S_SCORE2,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_CPU,
        OP_RATE,
        OP_TERM
    } div_op_t;

endpackage

`default_nettype wire

// ===== design/load_score_monitor_unit.sv =====
// load_score_monitor_unit: cpu load, byte rate, load score and busy flag
// from sampled cumulative counters; one shared restoring divider
// depends on lsm_pkg
// an accepted sample runs up to three passes of the shared restoring divider
// (cpu, rate, term) plus setup and scoring; the cpu pass is skipped with cpu_off
// or a zero ticks-per-second or wall delta, and net_off skips the rate and term
// passes; output stalls hold the result; in_stall is high while working
// the first sample after reset only primes the stored counters, no result
// reset clears the stored sample and loads the register defaults
`default_nettype none

module load_score_monitor_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [lsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lsm_pkg::CFG_W-1:0]         cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [lsm_pkg::CNT_W-1:0]         cpu_ticks,
    input  wire logic [lsm_pkg::CNT_W-1:0]         wall_time_ms,
    input  wire logic [lsm_pkg::CNT_W-1:0]         net_bytes,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lsm_pkg::Q_W-1:0]                cpu_util,
    output logic [lsm_pkg::RATE_W-1:0]             byte_rate,
    output logic [lsm_pkg::Q_W-1:0]                node_score,
    output logic                                   busy_res
);

    // configuration
    logic [lsm_pkg::IV_W-1:0]  interval_reg;
    logic [lsm_pkg::TPS_W-1:0] tps_reg;
    logic [lsm_pkg::BW_W-1:0]  bw_reg;
    logic [lsm_pkg::WGT_W-1:0] cpu_wgt_reg;
    logic [lsm_pkg::WGT_W-1:0] net_wgt_reg;
    logic [lsm_pkg::WGT_W-1:0] busy_thr_reg;
    logic                      cpu_off_reg;
    logic                      net_off_reg;

    // control
    lsm_pkg::state_t  state_reg, state_next;
    lsm_pkg::div_op_t op_reg;
    logic             primed_reg;
    logic             out_valid_reg;
    logic [lsm_pkg::IT_W-1:0] it_reg;

    // sample store and deltas
    logic [lsm_pkg::CNT_W-1:0] last_ticks_reg, last_wall_reg, last_bytes_reg;
    logic [lsm_pkg::CNT_W-1:0] d_ticks_reg, d_wall_reg, d_net_reg;

    // divider
    logic [lsm_pkg::NUM_W-1:0] num_reg;
    logic [lsm_pkg::NUM_W-1:0] quo_reg;
    logic [lsm_pkg::DEN_W-1:0] den_reg;
    logic [lsm_pkg::DEN_W-1:0] rem_reg;

    // results
    logic [lsm_pkg::Q_W-1:0]    load_reg, term_reg;
    logic [lsm_pkg::RATE_W-1:0] rate_reg;
    logic [lsm_pkg::PROD_W-1:0] prod_reg;
    logic [lsm_pkg::Q_W-1:0]    score_reg;
    logic                       busy_reg;
    logic [lsm_pkg::Q_W-1:0]    cpu_util_reg, node_score_reg;
    logic [lsm_pkg::RATE_W-1:0] byte_rate_reg;
    logic                       busy_res_reg;

    logic accept;
    logic out_load;
    logic div_last;
    logic cpu_skip;

    // datapath helpers
    logic [lsm_pkg::DEN_W:0]   rem_sh;
    logic                      div_ge;
    logic [lsm_pkg::DEN_W-1:0] rem_new;
    logic [lsm_pkg::NUM_W-1:0] quo_new;
    logic [lsm_pkg::NUM_W-1:0] cap_q;
    logic [lsm_pkg::NUM_W-1:0] quo_capped;
    logic [lsm_pkg::CNT_W+lsm_pkg::MS_W-1:0] ticks_ms, net_ms;
    logic [lsm_pkg::DEN_W-1:0] wall_tps;
    logic [lsm_pkg::IV_W-1:0]  iv_eff;
    logic [lsm_pkg::BW_W-1:0]  bw_eff;
    logic [lsm_pkg::SUM_W-1:0] score_sum;
    logic [lsm_pkg::SCORE_W-1:0] score_sh;
    logic [lsm_pkg::Q_W-1:0]   score_cl;

    assign accept   = in_valid && !in_stall;
    assign div_last = (it_reg == lsm_pkg::IT_W'(lsm_pkg::NUM_W - 1));
    assign cpu_skip = cpu_off_reg || (tps_reg == '0) || (d_wall_reg == '0);

    // shared divider step
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[lsm_pkg::NUM_W-1]};
        div_ge  = (rem_sh >= {1'b0, den_reg});
        rem_new = div_ge ? lsm_pkg::DEN_W'(rem_sh - {1'b0, den_reg})
                         : rem_sh[lsm_pkg::DEN_W-1:0];
        quo_new = {quo_reg[lsm_pkg::NUM_W-2:0], div_ge};
        unique case (op_reg)
            lsm_pkg::OP_RATE: cap_q = lsm_pkg::NUM_W'(lsm_pkg::RATE_MAX);
            default:          cap_q = lsm_pkg::NUM_W'(lsm_pkg::ONE_Q);
        endcase
        quo_capped = (quo_new > cap_q) ? cap_q : quo_new;
    end

    // multipliers feeding registers
    always_comb
    begin
        ticks_ms = d_ticks_reg * lsm_pkg::MS_PER_S;
        net_ms   = d_net_reg * lsm_pkg::MS_PER_S;
        wall_tps = d_wall_reg * tps_reg;
        iv_eff   = (interval_reg == '0) ? lsm_pkg::IV_W'(1) : interval_reg;
        bw_eff   = (bw_reg == '0) ? lsm_pkg::BW_W'(1) : bw_reg;
    end

    // score
    always_comb
    begin
        score_sum = lsm_pkg::SUM_W'(prod_reg)
                  + lsm_pkg::SUM_W'(lsm_pkg::PROD_W'(net_wgt_reg)
                                    * lsm_pkg::PROD_W'(term_reg));
        score_sh  = score_sum[lsm_pkg::SUM_W-1:lsm_pkg::FRAC_W];
        score_cl  = (score_sh > lsm_pkg::SCORE_W'(lsm_pkg::ONE_Q))
                    ? lsm_pkg::ONE_Q : score_sh[lsm_pkg::Q_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lsm_pkg::S_IDLE:
            begin
                if (accept && primed_reg)
                    state_next = lsm_pkg::S_CPU_SET;
            end
            lsm_pkg::S_CPU_SET:
            begin
                state_next = cpu_skip ? lsm_pkg::S_RATE_SET : lsm_pkg::S_DIV;
            end
            lsm_pkg::S_RATE_SET:
            begin
                state_next = net_off_reg ? lsm_pkg::S_SCORE1 : lsm_pkg::S_DIV;
            end
            lsm_pkg::S_TERM_SET:
            begin
                state_next = lsm_pkg::S_DIV;
            end
            lsm_pkg::S_DIV:
            begin
                if (div_last)
                begin
                    unique case (op_reg)
                        lsm_pkg::OP_CPU:  state_next = lsm_pkg::S_RATE_SET;
                        lsm_pkg::OP_RATE: state_next = lsm_pkg::S_TERM_SET;
                        default:          state_next = lsm_pkg::S_SCORE1;
                    endcase
                end
            end
            lsm_pkg::S_SCORE1:
            begin
                state_next = lsm_pkg::S_SCORE2;
            end
            lsm_pkg::S_SCORE2:
            begin
                state_next = lsm_pkg::S_OUT;
            end
            lsm_pkg::S_OUT:
            begin
                if (out_load)
                    state_next = lsm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lsm_pkg::S_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_stall = (state_reg != lsm_pkg::S_IDLE);
        out_load = (state_reg == lsm_pkg::S_OUT) && (!out_valid_reg || !out_stall);
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lsm_pkg::S_IDLE;
            op_reg         <= lsm_pkg::OP_CPU;
            primed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            it_reg         <= '0;
            last_ticks_reg <= '0;
            last_wall_reg  <= '0;
            last_bytes_reg <= '0;
            interval_reg   <= lsm_pkg::RST_INTERVAL;
            tps_reg        <= lsm_pkg::RST_TPS;
            bw_reg         <= lsm_pkg::RST_BW;
            cpu_wgt_reg    <= lsm_pkg::RST_CPU_WGT;
            net_wgt_reg    <= lsm_pkg::RST_NET_WGT;
            busy_thr_reg   <= lsm_pkg::RST_BUSY_THR;
            cpu_off_reg    <= 1'b0;
            net_off_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (lsm_pkg::cfg_reg_t'(cfg_index))
                    lsm_pkg::REG_SAMPLE_INTERVAL: interval_reg <= cfg_data[lsm_pkg::IV_W-1:0];
                    lsm_pkg::REG_TICKS_PER_SEC:   tps_reg      <= cfg_data[lsm_pkg::TPS_W-1:0];
                    lsm_pkg::REG_MAX_BANDWIDTH:   bw_reg       <= cfg_data[lsm_pkg::BW_W-1:0];
                    lsm_pkg::REG_CPU_WEIGHT:      cpu_wgt_reg  <= cfg_data[lsm_pkg::WGT_W-1:0];
                    lsm_pkg::REG_NET_WEIGHT:      net_wgt_reg  <= cfg_data[lsm_pkg::WGT_W-1:0];
                    lsm_pkg::REG_BUSY_THRESHOLD:  busy_thr_reg <= cfg_data[lsm_pkg::WGT_W-1:0];
                    lsm_pkg::REG_CPU_OFF:         cpu_off_reg  <= cfg_data[0];
                    lsm_pkg::REG_NET_OFF:         net_off_reg  <= cfg_data[0];
                    default:                      ;
                endcase
            end

            if (accept)
            begin
                primed_reg     <= 1'b1;
                last_ticks_reg <= cpu_ticks;
                last_wall_reg  <= wall_time_ms;
                last_bytes_reg <= net_bytes;
            end

            unique case (state_reg)
                lsm_pkg::S_CPU_SET:
                begin
                    op_reg <= lsm_pkg::OP_CPU;
                    it_reg <= '0;
                end
                lsm_pkg::S_RATE_SET:
                begin
                    op_reg <= lsm_pkg::OP_RATE;
                    it_reg <= '0;
                end
                lsm_pkg::S_TERM_SET:
                begin
                    op_reg <= lsm_pkg::OP_TERM;
                    it_reg <= '0;
                end
                lsm_pkg::S_DIV:
                begin
                    it_reg <= it_reg + lsm_pkg::IT_W'(1);
                end
                default:
                begin
                end
            endcase

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_ticks_reg <= cpu_ticks - last_ticks_reg;
            d_wall_reg  <= wall_time_ms - last_wall_reg;
            d_net_reg   <= (net_bytes > last_bytes_reg) ? net_bytes - last_bytes_reg : '0;
        end

        unique case (state_reg)
            lsm_pkg::S_CPU_SET:
            begin
                num_reg  <= {ticks_ms, lsm_pkg::FRAC_W'(0)};
                den_reg  <= wall_tps;
                rem_reg  <= '0;
                quo_reg  <= '0;
                load_reg <= '0;
            end
            lsm_pkg::S_RATE_SET:
            begin
                num_reg  <= {lsm_pkg::FRAC_W'(0), net_ms};
                den_reg  <= lsm_pkg::DEN_W'(iv_eff);
                rem_reg  <= '0;
                quo_reg  <= '0;
                rate_reg <= '0;
                term_reg <= '0;
            end
            lsm_pkg::S_TERM_SET:
            begin
                num_reg <= {(lsm_pkg::NUM_W - lsm_pkg::RATE_W - lsm_pkg::FRAC_W)'(0),
                            rate_reg, lsm_pkg::FRAC_W'(0)};
                den_reg <= lsm_pkg::DEN_W'(bw_eff);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            lsm_pkg::S_DIV:
            begin
                num_reg <= {num_reg[lsm_pkg::NUM_W-2:0], 1'b0};
                rem_reg <= rem_new;
                quo_reg <= quo_new;
                if (div_last)
                begin
                    unique case (op_reg)
                        lsm_pkg::OP_CPU:  load_reg <= quo_capped[lsm_pkg::Q_W-1:0];
                        lsm_pkg::OP_RATE: rate_reg <= quo_capped[lsm_pkg::RATE_W-1:0];
                        default:          term_reg <= quo_capped[lsm_pkg::Q_W-1:0];
                    endcase
                end
            end
            lsm_pkg::S_SCORE1:
            begin
                prod_reg <= cpu_wgt_reg * load_reg;
            end
            lsm_pkg::S_SCORE2:
            begin
                score_reg <= score_cl;
                busy_reg  <= (score_cl >= busy_thr_reg);
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            cpu_util_reg   <= load_reg;
            byte_rate_reg  <= rate_reg;
            node_score_reg <= score_reg;
            busy_res_reg   <= busy_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cpu_util   = cpu_util_reg;
    assign byte_rate  = byte_rate_reg;
    assign node_score = node_score_reg;
    assign busy_res   = busy_res_reg;

endmodule

`default_nettype wire
